>>> rtl/peer_wire_message_parser_unit_macros.svh
// assertion macros for the peer wire parser checker
// no dependencies
`ifndef PEER_WIRE_MESSAGE_PARSER_UNIT_MACROS_SVH
`define PEER_WIRE_MESSAGE_PARSER_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define PWP_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("pwp check failed");
// next-cycle implication
`define PWP_ASSERT_NXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("pwp check failed");
`endif

>>> rtl/pwp_pkg.sv
// shared types and constants of the peer wire parser
// no dependencies
package pwp_pkg;
  localparam int MaxLenW = 21;
  localparam logic [20:0] MaxLenReset = 21'd65536;
  localparam int QueueDepth = 4;

  typedef enum logic [4:0] {
    EV_HS_OK = 5'd0, EV_PEER_ID = 5'd1, EV_KEEPALIVE = 5'd2, EV_CHOKE = 5'd3,
    EV_UNCHOKE = 5'd4, EV_INTERESTED = 5'd5, EV_NOT_INTERESTED = 5'd6,
    EV_HAVE = 5'd7, EV_BF_START = 5'd8, EV_BF_BYTE = 5'd9, EV_REQUEST = 5'd10,
    EV_BLOCK_HDR = 5'd11, EV_BLOCK_BYTE = 5'd12, EV_EXT_START = 5'd13,
    EV_EXT_BYTE = 5'd14, EV_OTHER = 5'd15, EV_BAD_PROTO = 5'd16,
    EV_BAD_HASH = 5'd17, EV_TOO_LONG = 5'd18
  } event_t;

  typedef enum logic [2:0] {
    PH_HANDSHAKE, PH_LENGTH, PH_ID, PH_PAYLOAD, PH_CLOSED
  } phase_t;

  localparam logic [1:0] REG_HASH_HIGH = 2'd0;
  localparam logic [1:0] REG_HASH_MIDDLE = 2'd1;
  localparam logic [1:0] REG_HASH_LOW = 2'd2;
  localparam logic [1:0] REG_MAX_LEN = 2'd3;

  localparam logic [7:0] ID_CHOKE = 8'd0, ID_UNCHOKE = 8'd1, ID_INTERESTED = 8'd2;
  localparam logic [7:0] ID_NOT_INTERESTED = 8'd3, ID_HAVE = 8'd4;
  localparam logic [7:0] ID_BITFIELD = 8'd5, ID_REQUEST = 8'd6, ID_PIECE = 8'd7;
  localparam logic [7:0] ID_EXTENDED = 8'd20;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  data;
    logic [31:0] piece;
    logic [31:0] offset;
    logic [31:0] len;
    logic        last;
    logic        choking;
    logic        interested;
    logic        ext;
    logic        closed;
  } result_t;

  function automatic logic [7:0] proto_char(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0: c = "B";  5'd1: c = "i";  5'd2: c = "t";  5'd3: c = "T";
      5'd4: c = "o";  5'd5: c = "r";  5'd6: c = "r";  5'd7: c = "e";
      5'd8: c = "n";  5'd9: c = "t";  5'd10: c = " "; 5'd11: c = "p";
      5'd12: c = "r"; 5'd13: c = "o"; 5'd14: c = "t"; 5'd15: c = "o";
      5'd16: c = "c"; 5'd17: c = "o"; 5'd18: c = "l";
      default: c = 8'd0;
    endcase
    return c;
  endfunction
endpackage

>>> rtl/pwp_front.sv
// front part: per-byte parser that classifies the stream into result items
// depends on pwp_pkg
module pwp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  output logic              in_ready,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  output logic              res_valid,
  output pwp_pkg::result_t  res,
  input  logic              q_full
);
  import pwp_pkg::*;

  logic [63:0] hash_high, hash_middle;
  logic [31:0] hash_low;
  logic [MaxLenW-1:0] max_len;
  phase_t phase, phase_next;
  logic [6:0] pos, pos_next;
  logic [31:0] len_acc, len_acc_next;
  logic [20:0] remaining, remaining_next;
  logic [7:0] kind, kind_next;
  logic [31:0] f_piece, f_piece_next, f_offset, f_offset_next, f_len, f_len_next;
  logic ext_bit, ext_bit_next, choked, choked_next, wants, wants_next;
  logic [7:0] hbyte;
  logic [4:0] hidx;
  logic [31:0] plen, k, acc_shift;
  logic [20:0] rem_dec;
  logic fire, emit;
  event_t ev;
  logic [7:0] r_data;
  logic [31:0] r_piece, r_off, r_len;
  logic r_last;

  assign in_ready = !q_full;
  assign fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_high <= '0;
      hash_middle <= '0;
      hash_low <= '0;
      max_len <= MaxLenReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HASH_HIGH: hash_high <= cfg_data;
        REG_HASH_MIDDLE: hash_middle <= cfg_data;
        REG_HASH_LOW: hash_low <= cfg_data[31:0];
        REG_MAX_LEN: max_len <= cfg_data[MaxLenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hidx = 5'(pos - 7'd28);
    if (hidx < 5'd8) hbyte = hash_high[8'(7 - hidx[2:0]) * 8 +: 8];
    else if (hidx < 5'd16) hbyte = hash_middle[8'(7 - hidx[2:0]) * 8 +: 8];
    else hbyte = hash_low[8'(3 - hidx[1:0]) * 8 +: 8];
  end

  always_comb begin
    phase_next = phase; pos_next = pos; len_acc_next = len_acc;
    remaining_next = remaining; kind_next = kind;
    f_piece_next = f_piece; f_offset_next = f_offset; f_len_next = f_len;
    ext_bit_next = ext_bit; choked_next = choked; wants_next = wants;
    emit = 1'b0; ev = EV_HS_OK; r_data = '0; r_piece = '0; r_off = '0;
    r_len = '0; r_last = 1'b0;
    plen = len_acc - 32'd1;
    k = plen - {11'd0, remaining};
    rem_dec = remaining - 21'd1;
    acc_shift = (pos == 7'd0) ? {24'd0, in_byte} : {len_acc[23:0], in_byte};
    case (phase)
      PH_HANDSHAKE: begin
        pos_next = pos + 7'd1;
        if (pos == 7'd0) begin
          if (in_byte != 8'd19) begin emit = 1'b1; ev = EV_BAD_PROTO; phase_next = PH_CLOSED; end
        end else if (pos < 7'd20) begin
          if (in_byte != proto_char(5'(pos - 7'd1))) begin
            emit = 1'b1; ev = EV_BAD_PROTO; phase_next = PH_CLOSED;
          end
        end else if (pos < 7'd28) begin
          if (pos == 7'd25) ext_bit_next = in_byte[4];
        end else if (pos < 7'd48) begin
          if (in_byte != hbyte) begin
            emit = 1'b1; ev = EV_BAD_HASH; phase_next = PH_CLOSED;
          end else if (pos == 7'd47) begin
            emit = 1'b1; ev = EV_HS_OK;
          end
        end else begin
          emit = 1'b1; ev = EV_PEER_ID; r_data = in_byte;
          if (pos >= 7'd67) begin
            r_last = 1'b1; phase_next = PH_LENGTH; pos_next = '0; len_acc_next = '0;
          end
        end
      end
      PH_LENGTH: begin
        len_acc_next = acc_shift;
        pos_next = pos + 7'd1;
        if (pos == 7'd3) begin
          pos_next = '0;
          if (acc_shift > {11'd0, max_len}) begin
            emit = 1'b1; ev = EV_TOO_LONG; phase_next = PH_CLOSED;
          end else if (acc_shift == 32'd0) begin
            emit = 1'b1; ev = EV_KEEPALIVE;
          end else phase_next = PH_ID;
        end
      end
      PH_ID: begin
        kind_next = in_byte;
        f_piece_next = '0; f_offset_next = '0; f_len_next = '0;
        remaining_next = plen[20:0];
        phase_next = (plen == 32'd0) ? PH_LENGTH : PH_PAYLOAD;
        pos_next = '0;
        emit = 1'b1;
        case (in_byte)
          ID_CHOKE: begin choked_next = 1'b1; ev = EV_CHOKE; end
          ID_UNCHOKE: begin choked_next = 1'b0; ev = EV_UNCHOKE; end
          ID_INTERESTED: begin wants_next = 1'b1; ev = EV_INTERESTED; end
          ID_NOT_INTERESTED: begin wants_next = 1'b0; ev = EV_NOT_INTERESTED; end
          ID_HAVE, ID_REQUEST, ID_PIECE: emit = 1'b0;
          ID_BITFIELD: begin ev = EV_BF_START; r_len = plen; end
          ID_EXTENDED: begin ev = EV_EXT_START; r_len = plen; end
          default: begin ev = EV_OTHER; r_data = in_byte; r_len = plen; end
        endcase
      end
      PH_PAYLOAD: begin
        remaining_next = rem_dec;
        if (rem_dec == 21'd0) begin phase_next = PH_LENGTH; pos_next = '0; end
        if (kind == ID_HAVE || kind == ID_REQUEST || kind == ID_PIECE) begin
          if (k < 32'd4) f_piece_next = {f_piece[23:0], in_byte};
          else if (k < 32'd8) f_offset_next = {f_offset[23:0], in_byte};
          else if (k < 32'd12) f_len_next = {f_len[23:0], in_byte};
        end
        case (kind)
          ID_HAVE: if (k == 32'd3) begin
            emit = 1'b1; ev = EV_HAVE; r_piece = f_piece_next;
          end
          ID_REQUEST: if (k == 32'd11) begin
            emit = 1'b1; ev = EV_REQUEST; r_piece = f_piece_next;
            r_off = f_offset_next; r_len = f_len_next;
          end
          ID_PIECE: begin
            if (k == 32'd7) begin
              emit = 1'b1; ev = EV_BLOCK_HDR; r_piece = f_piece_next;
              r_off = f_offset_next; r_len = plen - 32'd8;
            end else if (k > 32'd7) begin
              emit = 1'b1; ev = EV_BLOCK_BYTE; r_data = in_byte; r_last = rem_dec == 21'd0;
            end
          end
          ID_BITFIELD: begin
            emit = 1'b1; ev = EV_BF_BYTE; r_data = in_byte; r_last = rem_dec == 21'd0;
          end
          ID_EXTENDED: begin
            emit = 1'b1; ev = EV_EXT_BYTE; r_data = in_byte; r_last = rem_dec == 21'd0;
          end
          default: ;
        endcase
      end
      default: phase_next = PH_CLOSED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HANDSHAKE; pos <= '0; len_acc <= '0; remaining <= '0; kind <= '0;
      f_piece <= '0; f_offset <= '0; f_len <= '0;
      ext_bit <= 1'b0; choked <= 1'b1; wants <= 1'b0;
    end else if (fire) begin
      phase <= phase_next; pos <= pos_next; len_acc <= len_acc_next;
      remaining <= remaining_next; kind <= kind_next;
      f_piece <= f_piece_next; f_offset <= f_offset_next; f_len <= f_len_next;
      ext_bit <= ext_bit_next; choked <= choked_next; wants <= wants_next;
    end
  end

  assign res_valid = fire && emit;
  always_comb begin
    res.ev = ev; res.data = r_data; res.piece = r_piece; res.offset = r_off;
    res.len = r_len; res.last = r_last; res.choking = choked_next;
    res.interested = wants_next; res.ext = ext_bit_next;
    res.closed = phase_next == PH_CLOSED;
  end
endmodule

>>> rtl/pwp_queue.sv
// result queue between the parser and the output channel
// depends on pwp_pkg
module pwp_queue #(
  parameter int Depth = pwp_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  input  pwp_pkg::result_t wr_data,
  output logic             full,
  output logic             rd_valid,
  output pwp_pkg::result_t rd_data,
  input  logic             rd_ready
);
  import pwp_pkg::*;
  localparam int AW = $clog2(Depth);
  result_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] count;
  logic wr, rd;

  assign rd = rd_valid && rd_ready;
  assign wr = wr_valid;
  assign full = count == (AW+1)'(Depth);
  assign rd_valid = count != '0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + AW'(1);
      if (rd) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + AW'(1);
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

>>> rtl/peer_wire_message_parser_unit.sv
// top level of the peer wire message parser
// depends on pwp_pkg, pwp_front, pwp_queue
//
// receive side parser for the peer wire protocol. bytes of the peer stream
// enter on the s_axis channel, one per transaction, tdata = rx_byte.
// results leave on m_axis, at most one per input byte: tdata packs
// event_res, data_byte, piece_index, block_offset, item_length, the four
// status flags; tlast is last_byte.
// configuration: cfg_valid/cfg_ready with cfg_index 0..3 (info hash high,
// middle, low, max message length) and 64-bit cfg_data; write while idle.
// a result is registered in the result queue when its byte is taken and leaves from there on m_axis.
// throughput: one byte per cycle while the result queue is not full.
// a four-entry result queue parts the parser from the output; when the
// receiver stalls the queue fills and s_axis_tready drops while it is full.
// reset: handshake phase, flags cleared but choked set, queue empty,
// max length back to 65536, info hash zero.
module peer_wire_message_parser_unit #(
  parameter int QDepth = pwp_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // rx_byte
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // event_res[4:0] data_byte[12:5] piece_index[44:13] block_offset[76:45]
  // item_length[108:77] peer_choking_flag[109] peer_interested_flag[110]
  // extension_supported[111] link_closed[112], zero fill to 120
  output logic [119:0]  m_axis_tdata,
  output logic          m_axis_tlast,   // last_byte
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data
);
  import pwp_pkg::*;
  result_t res, q_out;
  logic res_valid, q_full;

  assign cfg_ready = 1'b1;

  pwp_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_byte(s_axis_tdata),
    .in_ready(s_axis_tready), .cfg_valid, .cfg_index, .cfg_data,
    .res_valid, .res, .q_full
  );

  pwp_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst, .wr_valid(res_valid), .wr_data(res), .full(q_full),
    .rd_valid(m_axis_tvalid), .rd_data(q_out), .rd_ready(m_axis_tready)
  );

  // pack the fields lowest first
  assign m_axis_tdata = {7'd0, q_out.closed, q_out.ext, q_out.interested,
                         q_out.choking, q_out.len, q_out.offset, q_out.piece,
                         q_out.data, q_out.ev};
  assign m_axis_tlast = q_out.last;
endmodule

>>> rtl/pwp_checker.sv
// port-level checks of the peer wire parser, bound to the top level
// depends on pwp_pkg and peer_wire_message_parser_unit_macros.svh
`include "peer_wire_message_parser_unit_macros.svh"
module pwp_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata,
  input logic         m_axis_tlast
);
  import pwp_pkg::*;
  // a stalled result holds
  `PWP_ASSERT_NXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // tlast only on peer id, bitfield, block and extended byte events
  `PWP_ASSERT_IMP(a_last_kind, clk, rst, m_axis_tvalid && m_axis_tlast,
    m_axis_tdata[4:0] == EV_PEER_ID || m_axis_tdata[4:0] == EV_BF_BYTE ||
    m_axis_tdata[4:0] == EV_BLOCK_BYTE || m_axis_tdata[4:0] == EV_EXT_BYTE)
  // error events always report the link closed
  `PWP_ASSERT_IMP(a_err_closed, clk, rst, m_axis_tvalid && m_axis_tdata[4:0] >= EV_BAD_PROTO,
    m_axis_tdata[112])
  // event codes stay in range
  `PWP_ASSERT_IMP(a_range, clk, rst, m_axis_tvalid, m_axis_tdata[4:0] <= EV_TOO_LONG)
endmodule

bind peer_wire_message_parser_unit pwp_checker u_pwp_checker (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

>>> test/peer_wire_message_parser_unit_tb.sv
// testbench of the peer wire message parser: handshake, message deframing and closing
// drives a byte stream on s_axis, predicts each event and checks it on m_axis
// depends on pwp_pkg and the peer_wire_message_parser_unit rtl
`timescale 1ns / 1ps

module peer_wire_message_parser_unit_tb;
  import pwp_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 10;
  localparam string ProtoText = "BitTorrent protocol";

  typedef struct {
    logic [4:0]  ev;
    logic [7:0]  data;
    logic [31:0] piece;
    logic [31:0] offset;
    logic [31:0] len;
    logic        last;
    logic        choking;
    logic        interested;
    logic        ext;
    logic        closed;
  } peer_event_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'd0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = 2'd0;
  logic [63:0]  cfg_data = 64'd0;

  peer_wire_message_parser_unit dut (.*);

  always #5 clk = ~clk;

  // expected events, oldest first
  peer_event_t event_queue[$];
  int  mismatches = 0;
  int  bytes_sent = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;

  // shadow of the parser's registers and state
  logic [63:0] hash_high, hash_middle;
  logic [31:0] hash_low;
  logic [20:0] max_len;
  phase_t      ph;
  int unsigned pos;
  logic [31:0] len_acc;
  logic [20:0] remain;
  logic [7:0]  kind;
  logic [31:0] fpiece, foffset, flength;
  logic        ext_bit, choked, wants;

  task automatic reset_shadow();
    hash_high = '0; hash_middle = '0; hash_low = '0; max_len = 21'd65536;
    ph = PH_HANDSHAKE; pos = 0; len_acc = '0; remain = '0; kind = '0;
    fpiece = '0; foffset = '0; flength = '0;
    ext_bit = 1'b0; choked = 1'b1; wants = 1'b0;
  endtask

  function automatic logic [7:0] hash_at(int unsigned i);
    if (i < 8) return hash_high[63 - 8*i -: 8];
    if (i < 16) return hash_middle[63 - 8*(i-8) -: 8];
    return hash_low[31 - 8*(i-16) -: 8];
  endfunction

  function automatic void push_event(logic [4:0] ev, logic [7:0] d, logic [31:0] pi,
                                     logic [31:0] off, logic [31:0] ln, logic lst);
    peer_event_t e;
    e.ev = ev; e.data = d; e.piece = pi; e.offset = off; e.len = ln; e.last = lst;
    e.choking = choked; e.interested = wants; e.ext = ext_bit;
    e.closed = (ph == PH_CLOSED);
    event_queue.insert(event_queue.size(), e);
  endfunction

  function automatic void close_link(logic [4:0] ev);
    ph = PH_CLOSED;
    push_event(ev, 0, 0, 0, 0, 0);
  endfunction

  // advance the shadow parser by one byte, queueing the event it causes
  function automatic void parse_byte(logic [7:0] b);
    int unsigned p;
    logic [31:0] plen, k;
    logic lst;
    case (ph)
      PH_HANDSHAKE: begin
        p = pos;
        pos = p + 1;
        if (p == 0) begin
          if (b != 8'd19) close_link(EV_BAD_PROTO);
        end else if (p < 20) begin
          if (b != ProtoText[p-1]) close_link(EV_BAD_PROTO);
        end else if (p < 28) begin
          if (p == 25) ext_bit = b[4];
        end else if (p < 48) begin
          if (b != hash_at(p - 28)) close_link(EV_BAD_HASH);
          else if (p == 47) push_event(EV_HS_OK, 0, 0, 0, 0, 0);
        end else if (p >= 67) begin
          ph = PH_LENGTH; pos = 0; len_acc = '0;
          push_event(EV_PEER_ID, b, 0, 0, 0, 1);
        end else begin
          push_event(EV_PEER_ID, b, 0, 0, 0, 0);
        end
      end
      PH_LENGTH: begin
        if (pos == 0) len_acc = '0;
        len_acc = {len_acc[23:0], b};
        pos++;
        if (pos == 4) begin
          pos = 0;
          if (len_acc > {11'd0, max_len}) close_link(EV_TOO_LONG);
          else if (len_acc == 0) push_event(EV_KEEPALIVE, 0, 0, 0, 0, 0);
          else ph = PH_ID;
        end
      end
      PH_ID: begin
        plen = len_acc - 1;
        kind = b;
        fpiece = '0; foffset = '0; flength = '0;
        remain = plen[20:0];
        ph = (plen == 0) ? PH_LENGTH : PH_PAYLOAD;
        pos = 0;
        case (b)
          ID_CHOKE: begin choked = 1'b1; push_event(EV_CHOKE, 0, 0, 0, 0, 0); end
          ID_UNCHOKE: begin choked = 1'b0; push_event(EV_UNCHOKE, 0, 0, 0, 0, 0); end
          ID_INTERESTED: begin wants = 1'b1; push_event(EV_INTERESTED, 0, 0, 0, 0, 0); end
          ID_NOT_INTERESTED: begin
            wants = 1'b0; push_event(EV_NOT_INTERESTED, 0, 0, 0, 0, 0);
          end
          ID_HAVE, ID_REQUEST, ID_PIECE: ;
          ID_BITFIELD: push_event(EV_BF_START, 0, 0, 0, plen, 0);
          ID_EXTENDED: push_event(EV_EXT_START, 0, 0, 0, plen, 0);
          default: push_event(EV_OTHER, b, 0, 0, plen, 0);
        endcase
      end
      PH_PAYLOAD: begin
        plen = len_acc - 1;
        k = plen - {11'd0, remain};
        remain = remain - 21'd1;
        lst = (remain == 0);
        if (lst) begin ph = PH_LENGTH; pos = 0; end
        if (kind == ID_HAVE || kind == ID_REQUEST || kind == ID_PIECE) begin
          if (k < 4) fpiece = {fpiece[23:0], b};
          else if (k < 8) foffset = {foffset[23:0], b};
          else if (k < 12) flength = {flength[23:0], b};
        end
        case (kind)
          ID_HAVE: if (k == 3) push_event(EV_HAVE, 0, fpiece, 0, 0, 0);
          ID_REQUEST: if (k == 11) push_event(EV_REQUEST, 0, fpiece, foffset, flength, 0);
          ID_PIECE: begin
            if (k == 7) push_event(EV_BLOCK_HDR, 0, fpiece, foffset, plen - 8, 0);
            else if (k > 7) push_event(EV_BLOCK_BYTE, b, 0, 0, 0, lst);
          end
          ID_BITFIELD: push_event(EV_BF_BYTE, b, 0, 0, 0, lst);
          ID_EXTENDED: push_event(EV_EXT_BYTE, b, 0, 0, 0, lst);
          default: ;
        endcase
      end
      default: ph = PH_CLOSED;
    endcase
  endfunction

  // one byte transaction on s_axis, with an occasional idle burst first
  task automatic send_byte(logic [7:0] b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    parse_byte(b);
    bytes_sent++;
  endtask

  // length prefix, id byte, then plen random payload bytes
  task automatic send_message(logic [7:0] id, int unsigned plen);
    logic [31:0] ln;
    ln = plen + 1;
    for (int i = 3; i >= 0; i--) send_byte(ln[8*i +: 8]);
    send_byte(id);
    repeat (plen) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_keepalive();
    repeat (4) send_byte(8'd0);
  endtask

  // wait until every expected event has come back, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (event_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HASH_HIGH: hash_high = value;
      REG_HASH_MIDDLE: hash_middle = value;
      REG_HASH_LOW: hash_low = value[31:0];
      default: max_len = value[20:0];
    endcase
  endtask

  task automatic test_handshake();
    logic [7:0] r;
    write_reg(REG_HASH_HIGH, {$urandom, $urandom});
    write_reg(REG_HASH_MIDDLE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_HASH_LOW, {32'd0, $urandom});
    send_byte(8'd19);
    for (int i = 0; i < 19; i++) send_byte(ProtoText[i]);
    for (int i = 20; i < 28; i++) begin
      r = 8'($urandom_range(0, 255));
      if (i == 25) r[4] = 1'b1;  // extension protocol bit
      send_byte(r);
    end
    for (int i = 0; i < 20; i++) send_byte(hash_at(i));
    send_byte(8'hFF);
    send_byte(8'h00);
    repeat (18) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed_messages();
    send_keepalive();
    send_message(ID_UNCHOKE, 0);
    send_message(ID_INTERESTED, 0);
    send_message(ID_CHOKE, 2);            // flag message with trailing bytes
    send_message(ID_NOT_INTERESTED, 0);
    send_message(ID_HAVE, 4);
    send_message(ID_HAVE, 2);             // short have, no event
    send_message(ID_HAVE, 6);             // long have
    send_message(ID_REQUEST, 12);
    send_message(ID_REQUEST, 7);          // short request
    send_message(ID_REQUEST, 15);         // long request
    send_message(ID_PIECE, 8);            // header only
    send_message(ID_PIECE, 11);
    send_message(ID_PIECE, 5);            // short piece
    send_message(ID_BITFIELD, 0);         // empty bitfield
    send_message(ID_BITFIELD, 3);
    send_message(ID_EXTENDED, 0);         // empty extended
    send_message(ID_EXTENDED, 4);
    send_message(8'd8, 12);               // cancel
    send_message(8'd9, 2);                // port
    send_message(8'hFF, 1);               // unknown id
    drain();
    // smallest allowed maximum, a request exactly at it
    write_reg(REG_MAX_LEN, 64'd13);
    send_message(ID_REQUEST, 12);
    send_message(ID_PIECE, 12);
  endtask

  task automatic send_random_message();
    int unsigned pmax, plen;
    logic [7:0] id;
    pmax = 32'(max_len) - 1;
    plen = $urandom_range(0, 3);
    case ($urandom_range(0, 11))
      0: begin send_keepalive(); return; end
      1, 2: id = 8'($urandom_range(ID_CHOKE, ID_NOT_INTERESTED));
      3: begin id = ID_HAVE; plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4; end
      4: begin
        id = ID_REQUEST;
        plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 12;
      end
      5, 6: begin
        id = ID_PIECE;
        plen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 16);
      end
      7: begin id = ID_BITFIELD; plen = $urandom_range(0, 8); end
      8: begin id = ID_EXTENDED; plen = $urandom_range(0, 8); end
      9: begin
        id = 8'($urandom_range(8, 255));
        if (id == ID_EXTENDED) id = 8'd21;
        plen = $urandom_range(0, 6);
      end
      default: begin
        id = $urandom_range(0, 1) ? ID_PIECE : ID_BITFIELD;
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      end
    endcase
    if (plen > pmax) plen = pmax;
    send_message(id, plen);
  endtask

  task automatic test_random_stream();
    logic [20:0] settings[4];
    settings = '{21'd1048576, 21'd13, 21'd14 + 21'($urandom_range(0, 40)), 21'd65536};
    foreach (settings[s]) begin
      drain();
      write_reg(REG_MAX_LEN, {43'd0, settings[s]});
      while (bytes_sent < 150 * (s + 1) + 180) send_random_message();
    end
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    repeat (20) send_random_message();
  endtask

  // length one above the maximum closes the link, later bytes give nothing
  task automatic test_too_long();
    logic [31:0] ln;
    drain();
    write_reg(REG_MAX_LEN, 64'($urandom_range(13, 1048575)));
    ln = {11'd0, max_len} + 1;
    for (int i = 3; i >= 0; i--) send_byte(ln[8*i +: 8]);
    send_message(ID_UNCHOKE, 0);
    repeat (8) send_byte(8'($urandom_range(0, 255)));
  endtask

  // result side: random stalls, check each transaction against the oldest expectation
  always @(posedge clk) begin
    peer_event_t e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (event_queue.size() == 0) begin
          $error("unexpected result transaction, event %0d", m_axis_tdata[4:0]);
          mismatches++;
        end else begin
          e = event_queue.pop_front();
          if (m_axis_tdata[4:0] !== e.ev) begin
            $error("event_res exp %0d act %0d", e.ev, m_axis_tdata[4:0]); mismatches++;
          end
          if (m_axis_tdata[12:5] !== e.data) begin
            $error("data_byte exp %0h act %0h", e.data, m_axis_tdata[12:5]); mismatches++;
          end
          if (m_axis_tdata[44:13] !== e.piece) begin
            $error("piece_index exp %0h act %0h", e.piece, m_axis_tdata[44:13]); mismatches++;
          end
          if (m_axis_tdata[76:45] !== e.offset) begin
            $error("block_offset exp %0h act %0h", e.offset, m_axis_tdata[76:45]);
            mismatches++;
          end
          if (m_axis_tdata[108:77] !== e.len) begin
            $error("item_length exp %0h act %0h", e.len, m_axis_tdata[108:77]); mismatches++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last_byte exp %0b act %0b", e.last, m_axis_tlast); mismatches++;
          end
          if (m_axis_tdata[109] !== e.choking) begin
            $error("peer_choking_flag exp %0b act %0b", e.choking, m_axis_tdata[109]);
            mismatches++;
          end
          if (m_axis_tdata[110] !== e.interested) begin
            $error("peer_interested_flag exp %0b act %0b", e.interested, m_axis_tdata[110]);
            mismatches++;
          end
          if (m_axis_tdata[111] !== e.ext) begin
            $error("extension_supported exp %0b act %0b", e.ext, m_axis_tdata[111]);
            mismatches++;
          end
          if (m_axis_tdata[112] !== e.closed) begin
            $error("link_closed exp %0b act %0b", e.closed, m_axis_tdata[112]); mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_handshake();
    test_directed_messages();
    test_random_stream();
    test_quiet_tail();
    test_too_long();
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
